[rtl/core/drt_pkg.sv]
// Package for the dirty rectangle tracker: word types, op and register codes,
// size limits and the screen size clamp. No dependencies.
`timescale 1ns / 1ps

package drt_pkg;

  // Largest screen dimension accepted by the size registers
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = 13;
  localparam int POS_W   = 16;
  localparam int CNT_W   = 32;

  // Screen size after reset: 4096 limited to MAX_DIM
  localparam logic [DIM_W-1:0] RST_DIM =
    (MAX_DIM < 4096) ? DIM_W'(MAX_DIM) : DIM_W'(4096);

  // Operation codes
  localparam logic [1:0] OP_PIXEL      = 2'd0;
  localparam logic [1:0] OP_FRAME_END  = 2'd1;
  localparam logic [1:0] OP_PART_RESET = 2'd2;

  // Configuration register indexes
  localparam logic CFG_SCREEN_WIDTH  = 1'b0;
  localparam logic CFG_SCREEN_HEIGHT = 1'b1;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic                    pixel_changed;
  } in_word_t;

  typedef struct packed {
    logic             out_of_bounds;
    logic [DIM_W-1:0] region_x_low;
    logic [DIM_W-1:0] region_y_low;
    logic [DIM_W-1:0] region_width;
    logic [DIM_W-1:0] region_height;
    logic [CNT_W-1:0] changed_count;
  } out_word_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } screen_t;

  typedef struct packed {
    logic [DIM_W-1:0] x_low;
    logic [DIM_W-1:0] y_low;
    logic [DIM_W-1:0] x_high;
    logic [DIM_W-1:0] y_high;
  } box_t;

  // Zero reads as one, anything above MAX_DIM saturates
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

endpackage

[rtl/core/drt_cfg.sv]
// Screen size registers of the dirty rectangle tracker.
// Depends on drt_pkg for the register codes and the clamp function.
`timescale 1ns / 1ps

module drt_cfg (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [drt_pkg::DIM_W-1:0] cfg_data,
  output drt_pkg::screen_t          scr
);
  import drt_pkg::*;

  screen_t scr_r, scr_nxt;

  assign cfg_ready = 1'b1;
  assign scr       = scr_r;

  // Decode the register index, store the clamped size
  always_comb begin
    scr_nxt = scr_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCREEN_WIDTH:  scr_nxt.width  = clamp_dim(cfg_data);
        CFG_SCREEN_HEIGHT: scr_nxt.height = clamp_dim(cfg_data);
        default:           scr_nxt        = scr_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_r.width  <= RST_DIM;
      scr_r.height <= RST_DIM;
    end else begin
      scr_r <= scr_nxt;
    end
  end

endmodule

[rtl/core/drt_in_stage.sv]
// Input register of the dirty rectangle tracker: holds one word until the
// update logic takes it. Depends on drt_pkg for the input word type.
`timescale 1ns / 1ps

module drt_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  drt_pkg::in_word_t in_word,
  input  logic              adv,
  output logic              held_valid,
  output drt_pkg::in_word_t held_word
);
  import drt_pkg::*;

  logic     held_valid_r, held_valid_nxt;
  in_word_t held_word_r;
  logic     load;

  // Refill whenever the held word is empty or leaves this cycle
  assign in_stall = held_valid_r && !adv;
  assign load     = in_valid && !in_stall;

  assign held_valid_nxt = load || (held_valid_r && !adv);
  assign held_valid     = held_valid_r;
  assign held_word      = held_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      held_word_r <= in_word;
    end
  end

endmodule

[rtl/core/drt_box_core.sv]
// Box state and update logic of the dirty rectangle tracker: applies one
// word per cycle while adv is high and forms the union result. Depends on drt_pkg.
`timescale 1ns / 1ps

module drt_box_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  drt_pkg::in_word_t  word,
  input  drt_pkg::screen_t   scr,
  output drt_pkg::out_word_t res
);
  import drt_pkg::*;

  box_t             cur_r, cur_nxt;
  box_t             prev_r, prev_nxt;
  logic [CNT_W-1:0] tally_r, tally_nxt;

  logic             x_in, y_in, oob;
  logic [DIM_W-1:0] ux, uy, ux1, uy1;
  logic [DIM_W-1:0] xl, yl, xh, yh;

  // Bounds check on the signed coordinates
  assign x_in = !word.pos_x[POS_W-1] && (word.pos_x[POS_W-2:0] < (POS_W-1)'(scr.width));
  assign y_in = !word.pos_y[POS_W-1] && (word.pos_y[POS_W-2:0] < (POS_W-1)'(scr.height));
  assign oob  = (word.op == OP_PIXEL) && !(x_in && y_in);

  // In bounds the coordinate is below the screen size, so it fits DIM_W
  assign ux  = word.pos_x[DIM_W-1:0];
  assign uy  = word.pos_y[DIM_W-1:0];
  assign ux1 = ux + DIM_W'(1);
  assign uy1 = uy + DIM_W'(1);

  // Next box state for the operation
  always_comb begin
    cur_nxt   = cur_r;
    prev_nxt  = prev_r;
    tally_nxt = tally_r;
    unique case (word.op)
      OP_PIXEL: begin
        if (!oob && word.pixel_changed) begin
          if (ux < cur_r.x_low)   cur_nxt.x_low  = ux;
          if (uy < cur_r.y_low)   cur_nxt.y_low  = uy;
          if (ux1 > cur_r.x_high) cur_nxt.x_high = ux1;
          if (uy1 > cur_r.y_high) cur_nxt.y_high = uy1;
          if (tally_r != '1) tally_nxt = tally_r + CNT_W'(1);
        end
      end
      OP_FRAME_END: begin
        prev_nxt = cur_r;
        cur_nxt  = '{x_low: scr.width, y_low: scr.height, x_high: '0, y_high: '0};
        tally_nxt = '0;
      end
      OP_PART_RESET: begin
        cur_nxt  = '{x_low: '0, y_low: '0, x_high: scr.width, y_high: scr.height};
        prev_nxt = '{x_low: scr.width, y_low: scr.height, x_high: '0, y_high: '0};
        tally_nxt = '0;
      end
      default: begin
        cur_nxt = cur_r;
      end
    endcase
  end

  // Union of current and previous boxes after the update
  assign xl = (cur_nxt.x_low  < prev_nxt.x_low)  ? cur_nxt.x_low  : prev_nxt.x_low;
  assign yl = (cur_nxt.y_low  < prev_nxt.y_low)  ? cur_nxt.y_low  : prev_nxt.y_low;
  assign xh = (cur_nxt.x_high > prev_nxt.x_high) ? cur_nxt.x_high : prev_nxt.x_high;
  assign yh = (cur_nxt.y_high > prev_nxt.y_high) ? cur_nxt.y_high : prev_nxt.y_high;

  always_comb begin
    res.out_of_bounds = oob;
    res.region_x_low  = xl;
    res.region_y_low  = yl;
    res.region_width  = (xh > xl) ? (xh - xl) : scr.width;
    res.region_height = (yh > yl) ? (yh - yl) : scr.height;
    res.changed_count = tally_nxt;
  end

  // Advance state only when the word moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r   <= '{x_low: '0, y_low: '0, x_high: RST_DIM, y_high: RST_DIM};
      prev_r  <= '{x_low: RST_DIM, y_low: RST_DIM, x_high: '0, y_high: '0};
      tally_r <= '0;
    end else if (adv) begin
      cur_r   <= cur_nxt;
      prev_r  <= prev_nxt;
      tally_r <= tally_nxt;
    end
  end

endmodule

[rtl/core/dirty_rectangle_tracker.sv]
// Dirty rectangle tracker: tracks the screen region that needs a partial
// refresh and reports the union of the current and previous frame boxes.
//
// Usage:
//   Input channel (in_valid, in_stall, in_word): one operation per word,
//   pixel write, frame end or partial reset. Result channel (out_valid,
//   out_stall, out_word): exactly one result word per input word, in order.
//   Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): screen width
//   and height; write only while no words are in flight. cfg_ready is
//   always high.
//   Throughput: one word per cycle while the result is not stalled; the box
//   update, union and width/height subtract sit between the input register
//   and the result register.
//   Stall: a stalled result holds; the input register still takes one more
//   word, then in_stall rises until the result is taken.
//   Reset: synchronous active-low rst_n sets the screen size to 4096 (at most
//   MAX_DIM), the current box to the full screen, the previous box to empty
//   and the changed count to zero.
// Depends on drt_pkg, drt_cfg, drt_in_stage and drt_box_core.
`timescale 1ns / 1ps

module dirty_rectangle_tracker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  drt_pkg::in_word_t         in_word,
  output logic                      out_valid,
  input  logic                      out_stall,
  output drt_pkg::out_word_t        out_word,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic                      cfg_index,
  input  logic [drt_pkg::DIM_W-1:0] cfg_data
);
  import drt_pkg::*;

  screen_t   scr;
  logic      held_valid;
  in_word_t  held_word;
  out_word_t res;
  logic      adv;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;

  drt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .scr       (scr)
  );

  drt_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .adv        (adv),
    .held_valid (held_valid),
    .held_word  (held_word)
  );

  drt_box_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .word  (held_word),
    .scr   (scr),
    .res   (res)
  );

  // Move the held word on when the result register is free or drains now
  assign adv = held_valid && (!out_valid_r || !out_stall);

  assign out_valid_nxt = adv || (out_valid_r && out_stall);
  assign out_valid     = out_valid_r;
  assign out_word      = out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_word_r <= res;
    end
  end

  // A held word with a free receiver reaches the result register next cycle
  a_held_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (held_valid && !out_stall) |=> out_valid)
    else $error("held word did not reach the result register");

  // The input side only stalls while the input register is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> held_valid)
    else $error("input stalled with an empty input register");

  // A reported region is never zero wide or zero high
  a_region_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_word.region_width != '0 && out_word.region_height != '0))
    else $error("reported region has zero size");

endmodule
